// ===== sv/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared constants, codes and the command entry type of the text console
// glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int TEXT_COLUMNS_DEF = 80;
	localparam int TEXT_ROWS_DEF    = 30;
	localparam int GLYPH_HEIGHT_DEF = 16;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int COL_W       = 8;
	localparam int ROW_W       = 6;
	localparam int GH_W        = 6;
	localparam int GLYPH_COUNT = 96;
	localparam int GIDX_W      = 7;
	localparam int CELL_BYTES  = 24;
	localparam int TAB_STOP    = 8;
	localparam int PITCH_W     = 16;
	localparam int ADDR_W      = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [PITCH_W-1:0] LINE_PITCH_RESET = 16'd1920;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 1'd1;

	localparam logic [1:0] FUNC_PUT   = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] KIND_GLYPH  = 2'd0;
	localparam logic [1:0] KIND_SCROLL = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FIRST = 8'h20;
	localparam logic [7:0] CH_LAST  = 8'h7F;

	typedef struct packed {
		logic [1:0]        op;
		logic [GIDX_W-1:0] gidx;
		logic [3:0]        gline;
		logic [7:0]        gbits;
		logic              draw;
		logic              scroll;
		logic [COL_W-1:0]  col_old;
		logic [ROW_W-1:0]  row_old;
		logic [COL_W-1:0]  col_new;
		logic [ROW_W-1:0]  row_new;
	} tcgr_entry_t;

endpackage

// ===== sv/tcgr_ifs.sv =====
// ----------------------------------------------------------------------------
// tcgr interfaces
// Valid/ready channels for console commands and for framebuffer operations.
// ----------------------------------------------------------------------------
interface tcgr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_code;
	logic [3:0] glyph_line;
	logic [7:0] glyph_bits;

	modport source(output valid, func, char_code, glyph_line, glyph_bits, input ready);
	modport sink(input valid, func, char_code, glyph_line, glyph_bits, output ready);
endinterface

interface tcgr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] row_addr;
	logic [7:0]  pixel_mask;
	logic [6:0]  col_now;
	logic [4:0]  row_now;
	logic        last;

	modport source(output valid, kind, row_addr, pixel_mask, col_now, row_now, last,
		input ready);
	modport sink(input valid, kind, row_addr, pixel_mask, col_now, row_now, last,
		output ready);
endinterface

// ===== sv/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// tcgr_front
// Accepts command beats, tracks the text cursor and queues work for the back.
// ----------------------------------------------------------------------------
module tcgr_front import tcgr_pkg::*; #(
	parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
	parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tcgr_in_if.sink      cmd,
	input  logic         full,
	output logic         push,
	output tcgr_entry_t  entry
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic             acc;
	logic             printable;
	logic             draw;
	logic             scroll;
	logic             load_ok;
	logic [COL_W:0]   col_step;
	logic [ROW_W-1:0] row_step;
	logic [COL_W:0]   col_wrap;
	logic [ROW_W-1:0] row_wrap;
	logic [ROW_W-1:0] row_fin;

	assign cmd.ready = !full;
	assign acc       = cmd.valid && !full;
	assign printable = cmd.char_code inside {[CH_FIRST:CH_LAST]};
	assign load_ok   = printable && ({2'b00, cmd.glyph_line} < GH_W'(GLYPH_HEIGHT));

	always_comb begin
		col_step = {1'b0, col_q};
		row_step = row_q;
		draw     = 1'b0;
		if (cmd.char_code == CH_BS && col_q != '0) begin
			col_step = {1'b0, col_q} - (COL_W+1)'(1);
		end else if (cmd.char_code == CH_TAB) begin
			col_step = ({1'b0, col_q} + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
		end else if (cmd.char_code == CH_CR) begin
			col_step = '0;
		end else if (cmd.char_code == CH_LF) begin
			col_step = '0;
			row_step = row_q + ROW_W'(1);
		end else if (printable) begin
			draw     = 1'b1;
			col_step = {1'b0, col_q} + (COL_W+1)'(1);
		end
		if (col_step >= (COL_W+1)'(TEXT_COLUMNS)) begin
			col_wrap = '0;
			row_wrap = row_step + ROW_W'(1);
		end else begin
			col_wrap = col_step;
			row_wrap = row_step;
		end
		scroll  = row_wrap >= ROW_W'(TEXT_ROWS);
		row_fin = scroll ? ROW_W'(TEXT_ROWS - 1) : row_wrap;
	end

	always_comb begin
		entry.op      = OP_PUT;
		entry.gidx    = GIDX_W'(cmd.char_code - CH_FIRST);
		entry.gline   = cmd.glyph_line;
		entry.gbits   = cmd.glyph_bits;
		entry.draw    = draw;
		entry.scroll  = scroll;
		entry.col_old = col_q;
		entry.row_old = row_q;
		entry.col_new = col_wrap[COL_W-1:0];
		entry.row_new = row_fin;
		push          = 1'b0;
		case (cmd.func)
			FUNC_PUT: begin
				push = acc && (draw || scroll);
			end
			FUNC_LOAD: begin
				entry.op = OP_LOAD;
				push     = acc && load_ok;
			end
			FUNC_CLEAR: begin
				entry.op      = OP_CLEAR;
				entry.col_new = '0;
				entry.row_new = '0;
				push          = acc;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			case (cmd.func)
				FUNC_PUT: begin
					col_q <= col_wrap[COL_W-1:0];
					row_q <= row_fin;
				end
				FUNC_CLEAR: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/tcgr_queue.sv =====
// ----------------------------------------------------------------------------
// tcgr_queue
// Short FIFO of command entries between the front and the back.
// ----------------------------------------------------------------------------
module tcgr_queue import tcgr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tcgr_entry_t  push_entry,
	output logic         full,
	input  logic         pop,
	output tcgr_entry_t  pop_entry,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcgr_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ===== sv/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// tcgr_back
// Executes queued entries: glyph store writes, glyph row draws, scroll and
// clear beats, through a registered output stage.
// ----------------------------------------------------------------------------
module tcgr_back import tcgr_pkg::*; #(
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [ADDR_W-1:0]   frame_base,
	input  logic [PITCH_W-1:0]  line_pitch,
	input  logic                empty,
	input  tcgr_entry_t         entry,
	output logic                pop,
	tcgr_out_if.source          rsp
);

	localparam int MEM_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int LINE_W    = $clog2(GLYPH_HEIGHT);
	localparam int PROD_W    = ROW_W + PITCH_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_CELL   = 3'd2;
	localparam logic [2:0] ST_DRAW   = 3'd3;
	localparam logic [2:0] ST_SINGLE = 3'd4;

	logic [7:0]         mem [MEM_DEPTH];
	logic [2:0]         state_q;
	tcgr_entry_t        cmd_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [LINE_W-1:0]  line_q;
	logic [MEM_AW-1:0]  rd_addr_q;
	logic [7:0]         rd_data_q;

	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [7:0]         out_mask_q;
	logic [COL_W-1:0]   out_col_q;
	logic [ROW_W-1:0]   out_row_q;
	logic               out_last_q;

	logic               slot_free;
	logic               last_line;
	logic               rd_en;
	logic [MEM_AW-1:0]  rd_addr;
	logic [MEM_AW-1:0]  wr_addr;
	logic               out_load;
	logic [1:0]         out_kind_d;
	logic [ADDR_W-1:0]  out_addr_d;
	logic [7:0]         out_mask_d;
	logic               out_last_d;

	assign slot_free = !out_valid_q || rsp.ready;
	assign last_line = line_q == LINE_W'(GLYPH_HEIGHT - 1);
	assign pop       = (state_q == ST_IDLE) && !empty;
	assign wr_addr   = MEM_AW'(entry.gidx * GLYPH_HEIGHT) + MEM_AW'(entry.gline);
	assign rd_en     = (state_q == ST_CELL) || (state_q == ST_DRAW && slot_free && !last_line);
	assign rd_addr   = (state_q == ST_CELL) ? MEM_AW'(cmd_q.gidx * GLYPH_HEIGHT)
	                                        : rd_addr_q + MEM_AW'(1);

	always_ff @(posedge clk) begin
		if (pop && entry.op == OP_LOAD) mem[wr_addr] <= entry.gbits;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_comb begin
		out_load   = 1'b0;
		out_kind_d = KIND_GLYPH;
		out_addr_d = addr_q;
		out_mask_d = rd_data_q;
		out_last_d = 1'b1;
		case (state_q)
			ST_DRAW: begin
				out_load   = slot_free;
				out_last_d = last_line && !cmd_q.scroll;
			end
			ST_SINGLE: begin
				out_load   = slot_free;
				out_kind_d = (cmd_q.op == OP_CLEAR) ? KIND_CLEAR : KIND_SCROLL;
				out_addr_d = frame_base;
				out_mask_d = '0;
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)       out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (entry.op)
							OP_PUT:   state_q <= entry.draw ? ST_MUL : ST_SINGLE;
							OP_CLEAR: state_q <= ST_SINGLE;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL:  state_q <= ST_CELL;
				ST_CELL: state_q <= ST_DRAW;
				ST_DRAW: begin
					if (slot_free && last_line) state_q <= cmd_q.scroll ? ST_SINGLE : ST_IDLE;
				end
				ST_SINGLE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= entry;
		if (state_q == ST_MUL) prod_q <= cmd_q.row_old * line_pitch;
		if (state_q == ST_CELL) begin
			addr_q <= frame_base + ADDR_W'(prod_q * GLYPH_HEIGHT)
				+ ADDR_W'(cmd_q.col_old * CELL_BYTES);
			line_q <= '0;
		end else if (state_q == ST_DRAW && slot_free) begin
			addr_q <= addr_q + ADDR_W'(line_pitch);
			line_q <= line_q + LINE_W'(1);
		end
		if (rd_en) rd_addr_q <= rd_addr;
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_addr_q <= out_addr_d;
			out_mask_q <= out_mask_d;
			out_col_q  <= cmd_q.col_new;
			out_row_q  <= cmd_q.row_new;
			out_last_q <= out_last_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.row_addr   = out_addr_q;
	assign rsp.pixel_mask = out_mask_q;
	assign rsp.col_now    = out_col_q[6:0];
	assign rsp.row_now    = out_row_q[4:0];
	assign rsp.last       = out_last_q;

endmodule

// ===== sv/text_console_glyph_renderer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console engine: cursor control, glyph store and framebuffer row beats.
// ----------------------------------------------------------------------------
// Flow: a command beat reaches the queue in the cycle it is accepted; glyph rows
//   pass ST_MUL, ST_CELL and ST_DRAW into the output register, scroll and clear
//   beats ST_SINGLE. Throughput: one glyph row per cycle unless rsp stalls,
//   from the single glyph memory read port; a new entry waits for ST_IDLE.
// Reset: cursor homed, frame_base 0, line_pitch 1920; glyph memory not cleared.
module text_console_glyph_renderer_top import tcgr_pkg::*; #(
	parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
	parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
	parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	tcgr_in_if.sink                cmd,
	tcgr_out_if.source             rsp
);

	logic [ADDR_W-1:0]  frame_base_q;
	logic [PITCH_W-1:0] line_pitch_q;

	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	tcgr_entry_t        push_entry;
	tcgr_entry_t        pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
			line_pitch_q <= LINE_PITCH_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRAME_BASE: frame_base_q <= cfg_wdata[ADDR_W-1:0];
				REG_LINE_PITCH: line_pitch_q <= cfg_wdata[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	tcgr_front #(
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.TEXT_ROWS    (TEXT_ROWS),
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.full   (full),
		.push   (push),
		.entry  (push_entry)
	);

	tcgr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	tcgr_back #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_base (frame_base_q),
		.line_pitch (line_pitch_q),
		.empty      (empty),
		.entry      (pop_entry),
		.pop        (pop),
		.rsp        (rsp)
	);

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != KIND_GLYPH |-> rsp.last)
		else $error("scroll or clear beat without last");

	a_single_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != KIND_GLYPH |->
			rsp.row_addr == frame_base_q && rsp.pixel_mask == 8'd0)
		else $error("scroll or clear beat with wrong address or mask");

	a_clear_homes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == KIND_CLEAR |-> rsp.col_now == 7'd0 && rsp.row_now == 5'd0)
		else $error("clear beat without homed cursor");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

endmodule
